// ===== hw/rtl/a64e_pkg.sv =====
// ----------------------------------------------------------------------------
// a64e_pkg
// shared types, opcodes and error codes of the a64 instruction encoder
// ----------------------------------------------------------------------------
`default_nettype none
package a64e_pkg;

    localparam logic [3:0] ACT_ADDSUB_REG = 4'd0;
    localparam logic [3:0] ACT_ADDSUB_IMM = 4'd1;
    localparam logic [3:0] ACT_MUL_ADD    = 4'd2;
    localparam logic [3:0] ACT_SDIV       = 4'd3;
    localparam logic [3:0] ACT_LOGIC      = 4'd4;
    localparam logic [3:0] ACT_SHIFT      = 4'd5;
    localparam logic [3:0] ACT_MOVE_WIDE  = 4'd6;
    localparam logic [3:0] ACT_MOV_IMM    = 4'd7;
    localparam logic [3:0] ACT_LDST       = 4'd8;
    localparam logic [3:0] ACT_PAIR       = 4'd9;
    localparam logic [3:0] ACT_B          = 4'd10;
    localparam logic [3:0] ACT_BCOND      = 4'd11;
    localparam logic [3:0] ACT_CBZ        = 4'd12;
    localparam logic [3:0] ACT_REGBRANCH  = 4'd13;
    localparam logic [3:0] ACT_CSET       = 4'd14;
    localparam logic [3:0] ACT_MOV        = 4'd15;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_SP_ZR    = 4'd1;
    localparam logic [3:0] ERR_ZR_SP    = 4'd2;
    localparam logic [3:0] ERR_RANGE    = 4'd3;
    localparam logic [3:0] ERR_ALIGN    = 4'd4;
    localparam logic [3:0] ERR_WSHIFT   = 4'd5;
    localparam logic [3:0] ERR_OVERLAP  = 4'd6;
    localparam logic [3:0] ERR_SAME_LDP = 4'd7;
    localparam logic [3:0] ERR_AL_CSET  = 4'd8;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  variant;
        logic        wide_form;
        logic [5:0]  reg_d;
        logic [5:0]  reg_n;
        logic [5:0]  reg_m;
        logic [5:0]  reg_a;
        logic [3:0]  cond;
        logic        option_flag;
        logic [5:0]  chunk_shift;
        logic [63:0] value;
    } req_t;

    // front result: base word (or move-imm template) plus expansion info
    typedef struct packed {
        logic [31:0] word;      // first word, complete
        logic [3:0]  error_code;
        logic [31:0] k_base;    // movk template: sf | opc | rd
        logic [63:0] chunks;    // raw value for movk words
        logic [3:0]  kmask;     // chunks still to emit as movk after first
    } job_t;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  error_code;
        logic        last;
    } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/a64e_if.sv =====
// ----------------------------------------------------------------------------
// a64e_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none
interface a64e_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/a64e_front.sv =====
// ----------------------------------------------------------------------------
// a64e_front
// combinational checks and encoding of one request into a job
// ----------------------------------------------------------------------------
`default_nettype none
module a64e_front
    import a64e_pkg::*;
(
    input  wire req_t req,
    output job_t      job
);
    function automatic logic [4:0] zr(input logic [5:0] r, inout logic [3:0] e);
        if (r == 6'd32 && e == ERR_OK) e = ERR_SP_ZR;
        else if (r > 6'd32 && e == ERR_OK) e = ERR_RANGE;
        return r[4:0];
    endfunction

    function automatic logic [4:0] spr(input logic [5:0] r, inout logic [3:0] e);
        if (r == 6'd31 && e == ERR_OK) e = ERR_ZR_SP;
        else if (r > 6'd32 && e == ERR_OK) e = ERR_RANGE;
        return (r == 6'd32) ? 5'd31 : r[4:0];
    endfunction

    function automatic void seterr(inout logic [3:0] e, input logic [3:0] c);
        if (e == ERR_OK) e = c;
    endfunction

    always_comb
    begin
        logic [3:0]  e;
        logic [31:0] w, sfb;
        logic [4:0]  a, b, c, d;
        logic [63:0] v;
        logic [5:0]  amt, immr, imms, wm1;
        logic        neg, sf;
        logic [63:0] sc;
        logic [2:0]  zc, oc;
        logic        movn, first_found;
        logic [15:0] ch, skipv;
        logic [1:0]  fi;
        logic [3:0]  km;
        logic [2:0]  nch;
        logic [31:0] boff;
        e = ERR_OK; w = '0; a = '0; b = '0; c = '0; d = '0;
        v = req.value; sf = req.wide_form;
        sfb = sf ? 32'h8000_0000 : 32'h0;
        neg = v[63];
        wm1 = sf ? 6'd63 : 6'd31;
        amt = '0; immr = '0; imms = '0; sc = '0; zc = '0; oc = '0;
        movn = 1'b0; first_found = 1'b0; ch = '0; skipv = '0; fi = '0; km = '0;
        nch = sf ? 3'd4 : 3'd2; boff = '0;
        job = '0;
        unique case (req.action)
            ACT_ADDSUB_REG, ACT_SDIV, ACT_LOGIC:
            begin
                a = zr(req.reg_m, e); b = zr(req.reg_n, e); c = zr(req.reg_d, e);
                // add/sub: bit 30 is op, bit 29 sets flags
                if (req.action == ACT_ADDSUB_REG)
                    w = {1'b0, req.variant[0], req.variant[1], 5'b01011, 24'h0};
                else if (req.action == ACT_SDIV)
                    w = 32'h1AC0_0C00;
                else
                    w = {1'b0, req.variant, 5'b01010, 24'h0};
                w = w | sfb | {11'h0, a, 16'h0} | {22'h0, b, 5'h0} | {27'h0, c};
            end
            ACT_ADDSUB_IMM:
            begin
                if (neg || v > 64'd4095) seterr(e, ERR_RANGE);
                c = req.variant[1] ? zr(req.reg_d, e) : spr(req.reg_d, e);
                b = spr(req.reg_n, e);
                w = sfb | {1'b0, req.variant[0], req.variant[1], 5'b10001, 24'h0}
                    | {9'h0, req.option_flag, 22'h0} | {10'h0, v[11:0], 10'h0}
                    | {22'h0, b, 5'h0} | {27'h0, c};
            end
            ACT_MUL_ADD:
            begin
                a = zr(req.reg_m, e); d = zr(req.reg_a, e);
                b = zr(req.reg_n, e); c = zr(req.reg_d, e);
                w = sfb | 32'h1B00_0000 | {11'h0, a, 16'h0} | {16'h0, req.variant[0], 15'h0}
                    | {17'h0, d, 10'h0} | {22'h0, b, 5'h0} | {27'h0, c};
            end
            ACT_SHIFT:
            begin
                if (req.variant == 2'd3) seterr(e, ERR_RANGE);
                if (neg || v > {58'h0, wm1}) seterr(e, ERR_RANGE);
                amt = v[5:0] & wm1;
                if (req.variant == 2'd0)
                begin
                    immr = (6'd0 - amt) & wm1;
                    imms = wm1 - amt;
                end
                else
                begin
                    immr = amt;
                    imms = wm1;
                end
                b = zr(req.reg_n, e); c = zr(req.reg_d, e);
                w = (req.variant == 2'd2 ? 32'h1300_0000 : 32'h5300_0000)
                    | (sf ? 32'h8040_0000 : 32'h0) | {10'h0, immr, 16'h0}
                    | {16'h0, imms, 10'h0} | {22'h0, b, 5'h0} | {27'h0, c};
            end
            ACT_MOVE_WIDE:
            begin
                if (req.variant == 2'd3) seterr(e, ERR_RANGE);
                if (neg || v > 64'hFFFF) seterr(e, ERR_RANGE);
                if (req.chunk_shift[3:0] != 4'd0 || (!sf && req.chunk_shift[5]))
                    seterr(e, ERR_WSHIFT);
                c = zr(req.reg_d, e);
                w = sfb | (req.variant == 2'd0 ? 32'h5280_0000 :
                           req.variant == 2'd1 ? 32'h1280_0000 : 32'h7280_0000)
                    | {9'h0, req.chunk_shift[5:4], 21'h0} | {11'h0, v[15:0], 5'h0}
                    | {27'h0, c};
            end
            ACT_MOV_IMM:
            begin
                c = zr(req.reg_d, e);
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < nch)
                    begin
                        zc = zc + 3'(v[16*i +: 16] == 16'h0000);
                        oc = oc + 3'(v[16*i +: 16] == 16'hFFFF);
                    end
                end
                movn = oc > zc;
                skipv = movn ? 16'hFFFF : 16'h0000;
                for (int i = 0; i < 4; i++)
                begin
                    ch = v[16*i +: 16];
                    if (3'(i) < nch && ch != skipv)
                    begin
                        if (!first_found)
                        begin
                            first_found = 1'b1;
                            fi = 2'(i);
                        end
                        else
                            km[i] = 1'b1;
                    end
                end
                ch = v[16*fi +: 16];
                if (movn) ch = ~ch;
                if (!first_found) ch = 16'h0;
                w = sfb | (movn ? 32'h1280_0000 : 32'h5280_0000) | {9'h0, fi, 21'h0}
                    | {11'h0, ch, 5'h0} | {27'h0, c};
                job.k_base = sfb | 32'h7280_0000 | {27'h0, c};
                job.chunks = v;
                job.kmask  = km;
            end
            ACT_LDST, ACT_PAIR:
            begin
                // byte offset to element offset by arithmetic shift, exact when aligned
                if (sf ? (v[2:0] != 3'd0) : (v[1:0] != 2'd0)) seterr(e, ERR_ALIGN);
                sc = sf ? {{3{v[63]}}, v[63:3]} : {{2{v[63]}}, v[63:2]};
                if (req.action == ACT_LDST)
                begin
                    if (sc[63] || sc > 64'd4095) seterr(e, ERR_RANGE);
                    b = spr(req.reg_n, e); c = zr(req.reg_d, e);
                    w = (sf ? 32'hF900_0000 : 32'hB900_0000)
                        | {9'h0, req.variant[0], 22'h0} | {10'h0, sc[11:0], 10'h0}
                        | {22'h0, b, 5'h0} | {27'h0, c};
                end
                else
                begin
                    if (sc[63] ? (sc[63:6] != {58{1'b1}}) : (sc[63:6] != 58'h0))
                        seterr(e, ERR_RANGE);
                    b = spr(req.reg_n, e);
                    if (req.reg_n != 6'd32 && (req.reg_n == req.reg_d || req.reg_n == req.reg_m))
                        seterr(e, ERR_OVERLAP);
                    if (req.variant[0] && req.reg_d == req.reg_m) seterr(e, ERR_SAME_LDP);
                    a = zr(req.reg_m, e); c = zr(req.reg_d, e);
                    w = (sf ? 32'hA880_0000 : 32'h2880_0000)
                        | {7'h0, req.option_flag, 24'h0} | {9'h0, req.variant[0], 22'h0}
                        | {10'h0, sc[6:0], 15'h0} | {17'h0, a, 10'h0}
                        | {22'h0, b, 5'h0} | {27'h0, c};
                end
            end
            ACT_B, ACT_BCOND, ACT_CBZ:
            begin
                sc = {{2{v[63]}}, v[63:2]};
                if (v[1:0] != 2'd0)
                    seterr(e, ERR_ALIGN);
                else if (req.action == ACT_B)
                begin
                    if (sc[63] ? (sc[63:25] != {39{1'b1}}) : (sc[63:25] != 39'h0))
                        seterr(e, ERR_RANGE);
                end
                else if (sc[63] ? (sc[63:18] != {46{1'b1}}) : (sc[63:18] != 46'h0))
                    seterr(e, ERR_RANGE);
                if (v[1:0] == 2'd0) boff = sc[31:0];
                if (req.action == ACT_B)
                    w = 32'h1400_0000 | {req.variant[0], 31'h0} | {6'h0, boff[25:0]};
                else if (req.action == ACT_BCOND)
                    w = 32'h5400_0000 | {8'h0, boff[18:0], 5'h0} | {28'h0, req.cond};
                else
                begin
                    c = zr(req.reg_d, e);
                    w = sfb | 32'h3400_0000 | {7'h0, req.variant[0], 24'h0}
                        | {8'h0, boff[18:0], 5'h0} | {27'h0, c};
                end
            end
            ACT_REGBRANCH:
            begin
                if (req.variant == 2'd3) seterr(e, ERR_RANGE);
                b = zr(req.reg_n, e);
                w = (req.variant == 2'd1 ? 32'hD63F_0000 :
                     req.variant == 2'd2 ? 32'hD65F_0000 : 32'hD61F_0000)
                    | {22'h0, b, 5'h0};
            end
            ACT_CSET:
            begin
                if (req.cond == 4'd14) seterr(e, ERR_AL_CSET);
                c = zr(req.reg_d, e);
                w = sfb | 32'h1A80_0400 | 32'h001F_0000 | {16'h0, req.cond ^ 4'd1, 12'h0}
                    | 32'h0000_03E0 | {27'h0, c};
            end
            ACT_MOV:
            begin
                if (req.reg_d == 6'd32 || req.reg_n == 6'd32)
                begin
                    c = spr(req.reg_d, e); b = spr(req.reg_n, e);
                    w = sfb | 32'h1100_0000 | {22'h0, b, 5'h0} | {27'h0, c};
                end
                else
                begin
                    a = zr(req.reg_n, e); c = zr(req.reg_d, e);
                    w = sfb | 32'h2A00_0000 | {11'h0, a, 16'h0} | 32'h0000_03E0
                        | {27'h0, c};
                end
            end
            default: w = '0;
        endcase
        if (e != ERR_OK)
        begin
            job.word  = '0;
            job.kmask = '0;
        end
        else
            job.word = w;
        job.error_code = e;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/a64e_queue.sv =====
// ----------------------------------------------------------------------------
// a64e_queue
// short job fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
module a64e_queue
    import a64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);
    job_t      mem_reg [QDEPTH];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'(QDEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/a64e_back.sv =====
// ----------------------------------------------------------------------------
// a64e_back
// emits the words of one job, expanding movk chunks, into an output register
// ----------------------------------------------------------------------------
`default_nettype none
module a64e_back
    import a64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_pop,
    output logic      out_valid,
    output res_t      out_data,
    input  wire logic out_ready
);
    logic       busy_reg, busy_next;
    logic [3:0] km_reg, km_next;
    logic       ov_reg, ov_next;
    res_t       od_reg, od_next;
    logic [3:0] cur_mask;
    logic [1:0] idx;
    logic [3:0] rest;
    logic       load;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        load = !ov_reg || out_ready;
        busy_next = busy_reg;
        km_next = km_reg;
        ov_next = ov_reg && !out_ready;
        od_next = od_reg;
        job_pop = 1'b0;
        cur_mask = busy_reg ? km_reg : '0;
        idx = cur_mask[0] ? 2'd0 : cur_mask[1] ? 2'd1 : cur_mask[2] ? 2'd2 : 2'd3;
        rest = cur_mask & ~(4'd1 << idx);
        if (load)
        begin
            if (busy_reg)
            begin
                ov_next = 1'b1;
                od_next.word = job.k_base | {9'h0, idx, 21'h0}
                               | {11'h0, job.chunks[16*idx +: 16], 5'h0};
                od_next.error_code = ERR_OK;
                od_next.last = (rest == 4'd0);
                km_next = rest;
                if (rest == 4'd0)
                begin
                    busy_next = 1'b0;
                    job_pop = 1'b1;
                end
            end
            else if (job_valid)
            begin
                ov_next = 1'b1;
                od_next.word = job.word;
                od_next.error_code = job.error_code;
                od_next.last = (job.kmask == 4'd0);
                km_next = job.kmask;
                if (job.kmask == 4'd0)
                    job_pop = 1'b1;
                else
                    busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        km_reg <= km_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/a64_instruction_encoder.sv =====
// ----------------------------------------------------------------------------
// a64_instruction_encoder
// encodes one instruction request into one to four a64 words
// ----------------------------------------------------------------------------
// channel  dir  beat   payload
// req      in   req_t  form, variant, width, registers, cond, flags, value
// res      out  res_t  word, error_code, last
//
// one request per cycle while the queue is not full; a request gives one beat, move-immediate up to four
// the front checks and encodes combinationally and writes a two-entry job queue
// the back emits one beat per cycle into an output register while the receiver is ready
// movk expansion holds the job at the queue head until its last movk word is emitted
// rst_n clears queue pointers and the output valid; payload is not reset
// ----------------------------------------------------------------------------
`default_nettype none
module a64_instruction_encoder
    import a64e_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    a64e_if.sink     req,
    a64e_if.source   res
);
    job_t front_job, head_job;
    logic q_full, q_empty, q_pop;

    // front: check and encode
    a64e_front u_front (
        .req (req.data),
        .job (front_job)
    );

    assign req.ready = !q_full;

    // decoupling queue
    a64e_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req.valid && !q_full),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_job),
        .empty     (q_empty)
    );

    // back: word sequencing and output register
    a64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (head_job),
        .job_pop   (q_pop),
        .out_valid (res.valid),
        .out_data  (res.data),
        .out_ready (res.ready)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/a64e_checker.sv =====
// ----------------------------------------------------------------------------
// a64e_checker
// port-level checks of the encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module a64e_checker
    import a64e_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res_data
);
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.error_code != ERR_OK |-> res_data.last)
        else $error("error beat not last");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.error_code != ERR_OK |-> res_data.word == 32'h0)
        else $error("error beat with nonzero word");
    a_err_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.error_code <= ERR_AL_CSET)
        else $error("bad error code");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled beat changed");
endmodule

bind a64_instruction_encoder a64e_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
`default_nettype wire

// ===== sim/a64e_checker.sv =====
// ----------------------------------------------------------------------------
// a64e_scoreboard
// watches the request and result channels, predicts the a64 words of every
// accepted request and compares each result beat with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none
module a64e_scoreboard
    import a64e_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req_data,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res_data,
    output int       errors,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    res_t word_q[$];

    function automatic void set_err(ref logic [3:0] e, input logic [3:0] code);
        if (e == ERR_OK)
            e = code;
    endfunction

    function automatic logic [31:0] zr(input logic [5:0] r, ref logic [3:0] e);
        if (r == 6'd32) set_err(e, ERR_SP_ZR);
        else if (r > 6'd32) set_err(e, ERR_RANGE);
        return {27'd0, r[4:0]};
    endfunction

    function automatic logic [31:0] sp(input logic [5:0] r, ref logic [3:0] e);
        if (r == 6'd31) set_err(e, ERR_ZR_SP);
        else if (r > 6'd32) set_err(e, ERR_RANGE);
        return r == 6'd32 ? 32'd31 : {27'd0, r[4:0]};
    endfunction

    function automatic void rng(input longint v, input longint lo, input longint hi,
                                ref logic [3:0] e);
        if (v < lo || v > hi) set_err(e, ERR_RANGE);
    endfunction

    function automatic logic [31:0] br_off(input longint off, input int bits,
                                           ref logic [3:0] e);
        longint w, lim;
        logic [63:0] u;
        if (off % 4 != 0)
        begin
            set_err(e, ERR_ALIGN);
            return 32'd0;
        end
        w = off / 4;
        lim = longint'(1) << (bits - 1);
        rng(w, -lim, lim - 1, e);
        u = w;
        return u[31:0] & ((32'd1 << bits) - 1);
    endfunction

    // computes the words of one request and appends them to word_q
    function automatic void encode_request(input req_t q);
        logic [31:0] w[4];
        logic [31:0] a, b, c, d, sfb, width, amt, immr, imms, ch, skip;
        logic [3:0]  e;
        longint      v, size, sc;
        logic [63:0] scu;
        int          nw, zeros, ones, chunks;
        logic        movn;
        res_t        r;
        e = ERR_OK;
        nw = 1;
        w = '{default: 32'd0};
        v = q.value;
        sfb = q.wide_form ? 32'h8000_0000 : 32'd0;
        width = q.wide_form ? 32'd64 : 32'd32;
        case (q.action)
            ACT_ADDSUB_REG, ACT_SDIV, ACT_LOGIC:
            begin
                a = zr(q.reg_m, e); b = zr(q.reg_n, e); c = zr(q.reg_d, e);
                if (q.action == ACT_SDIV) d = 32'h1AC0_0C00;
                else if (q.action == ACT_LOGIC)
                    d = {1'b0, q.variant, 5'b01010, 24'd0};
                else d = {1'b0, q.variant[0], q.variant[1], 5'b01011, 24'd0};
                w[0] = sfb | d | a << 16 | b << 5 | c;
            end
            ACT_ADDSUB_IMM:
            begin
                rng(v, 0, 4095, e);
                c = q.variant[1] ? zr(q.reg_d, e) : sp(q.reg_d, e);
                b = sp(q.reg_n, e);
                w[0] = sfb | {1'b0, q.variant[0], q.variant[1], 5'b10001, 24'd0}
                     | q.option_flag << 22 | (v[11:0] << 10) | b << 5 | c;
            end
            ACT_MUL_ADD:
            begin
                a = zr(q.reg_m, e); d = zr(q.reg_a, e);
                b = zr(q.reg_n, e); c = zr(q.reg_d, e);
                w[0] = sfb | 32'h1B00_0000 | a << 16 | q.variant[0] << 15 | d << 10
                     | b << 5 | c;
            end
            ACT_SHIFT:
            begin
                if (q.variant == 2'd3) set_err(e, ERR_RANGE);
                rng(v, 0, longint'(width) - 1, e);
                amt = v[31:0] & (width - 1);
                if (q.variant == 2'd0)
                begin
                    immr = (width - amt) % width;
                    imms = width - 1 - amt;
                end
                else
                begin
                    immr = amt;
                    imms = width - 1;
                end
                b = zr(q.reg_n, e); c = zr(q.reg_d, e);
                w[0] = (q.variant == 2'd2 ? 32'h1300_0000 : 32'h5300_0000)
                     | (q.wide_form ? 32'h8040_0000 : 32'd0)
                     | immr << 16 | imms << 10 | b << 5 | c;
            end
            ACT_MOVE_WIDE:
            begin
                if (q.variant == 2'd3) set_err(e, ERR_RANGE);
                rng(v, 0, 65535, e);
                if (q.chunk_shift % 16 != 0 || q.chunk_shift >= width)
                    set_err(e, ERR_WSHIFT);
                c = zr(q.reg_d, e);
                case (q.variant)
                    2'd1: d = 32'h1280_0000;
                    2'd2: d = 32'h7280_0000;
                    default: d = 32'h5280_0000;
                endcase
                w[0] = sfb | d | {30'd0, q.chunk_shift[5:4]} << 21 | v[15:0] << 5 | c;
            end
            ACT_MOV_IMM:
            begin
                chunks = q.wide_form ? 4 : 2;
                zeros = 0; ones = 0;
                c = zr(q.reg_d, e);
                for (int i = 0; i < chunks; i++)
                begin
                    ch = {16'd0, q.value[16*i +: 16]};
                    zeros += (ch == 0);
                    ones += (ch == 32'hFFFF);
                end
                movn = ones > zeros;
                skip = movn ? 32'hFFFF : 32'd0;
                nw = 0;
                for (int i = 0; i < chunks; i++)
                begin
                    ch = {16'd0, q.value[16*i +: 16]};
                    if (ch != skip)
                    begin
                        if (nw == 0)
                            w[0] = sfb | (movn ? 32'h1280_0000 : 32'h5280_0000) | i << 21
                                 | ((movn ? ~ch : ch) & 32'hFFFF) << 5 | c;
                        else
                            w[nw] = sfb | 32'h7280_0000 | i << 21 | ch << 5 | c;
                        nw++;
                    end
                end
                if (nw == 0)
                begin
                    w[0] = sfb | (movn ? 32'h1280_0000 : 32'h5280_0000) | c;
                    nw = 1;
                end
            end
            ACT_LDST, ACT_PAIR:
            begin
                size = q.wide_form ? 8 : 4;
                if (v % size != 0) set_err(e, ERR_ALIGN);
                sc = v / size;
                scu = sc;
                if (q.action == ACT_LDST)
                begin
                    rng(sc, 0, 4095, e);
                    b = sp(q.reg_n, e); c = zr(q.reg_d, e);
                    w[0] = (q.wide_form ? 32'hF900_0000 : 32'hB900_0000)
                         | q.variant[0] << 22 | (scu[11:0] << 10) | b << 5 | c;
                end
                else
                begin
                    rng(sc, -64, 63, e);
                    b = sp(q.reg_n, e);
                    if (q.reg_n != 6'd32 && (q.reg_n == q.reg_d || q.reg_n == q.reg_m))
                        set_err(e, ERR_OVERLAP);
                    if (q.variant[0] && q.reg_d == q.reg_m) set_err(e, ERR_SAME_LDP);
                    a = zr(q.reg_m, e); c = zr(q.reg_d, e);
                    w[0] = (q.wide_form ? 32'hA880_0000 : 32'h2880_0000)
                         | q.option_flag << 24 | q.variant[0] << 22 | (scu[6:0] << 15)
                         | a << 10 | b << 5 | c;
                end
            end
            ACT_B:
            begin
                a = br_off(v, 26, e);
                w[0] = 32'h1400_0000 | q.variant[0] << 31 | a;
            end
            ACT_BCOND:
            begin
                a = br_off(v, 19, e);
                w[0] = 32'h5400_0000 | a << 5 | q.cond;
            end
            ACT_CBZ:
            begin
                a = br_off(v, 19, e);
                c = zr(q.reg_d, e);
                w[0] = sfb | 32'h3400_0000 | q.variant[0] << 24 | a << 5 | c;
            end
            ACT_REGBRANCH:
            begin
                if (q.variant == 2'd3) set_err(e, ERR_RANGE);
                b = zr(q.reg_n, e);
                case (q.variant)
                    2'd1: d = 32'hD63F_0000;
                    2'd2: d = 32'hD65F_0000;
                    default: d = 32'hD61F_0000;
                endcase
                w[0] = d | b << 5;
            end
            ACT_CSET:
            begin
                if (q.cond == 4'd14) set_err(e, ERR_AL_CSET);
                c = zr(q.reg_d, e);
                w[0] = sfb | 32'h1A80_0400 | 32'd31 << 16 | (q.cond ^ 4'd1) << 12
                     | 32'd31 << 5 | c;
            end
            default:
            begin
                if (q.reg_d == 6'd32 || q.reg_n == 6'd32)
                begin
                    c = sp(q.reg_d, e); b = sp(q.reg_n, e);
                    w[0] = sfb | 32'h1100_0000 | b << 5 | c;
                end
                else
                begin
                    a = zr(q.reg_n, e); c = zr(q.reg_d, e);
                    w[0] = sfb | 32'h2A00_0000 | a << 16 | 32'd31 << 5 | c;
                end
            end
        endcase
        if (e != ERR_OK)
        begin
            r.word = 32'd0; r.error_code = e; r.last = 1'b1;
            word_q.insert(word_q.size(), r);
        end
        else
            for (int k = 0; k < nw; k++)
            begin
                r.word = w[k]; r.error_code = ERR_OK; r.last = (k == nw - 1);
                word_q.insert(word_q.size(), r);
            end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            word_q.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (word_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result beat word=%h err=%0d last=%0d",
                                 res_data.word, res_data.error_code, res_data.last);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = word_q.pop_front();
                    if (exp_r !== res_data)
                    begin
                        if (errors < 10)
                            $display("mismatch exp word=%h err=%0d last=%0d got word=%h err=%0d last=%0d",
                                     exp_r.word, exp_r.error_code, exp_r.last,
                                     res_data.word, res_data.error_code, res_data.last);
                        errors <= errors + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                encode_request(req_data);
            pending <= word_q.size();
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random requests into the a64 encoder with random gaps
// and back-pressure; the checker predicts and compares every result beat
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import a64e_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 360;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_hold = 1'b0;     // long receiver hold-off
    int   errors, pending;
    int   idle_cycles = 0;

    a64e_if #(.T(req_t)) req (.clk(clk));
    a64e_if #(.T(res_t)) res (.clk(clk));

    a64_instruction_encoder i_dut (.clk(clk), .rst_n(rst_n), .req(req), .res(res));

    a64e_scoreboard i_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
        .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        req.valid = 1'b0;
        req.data = '0;
        res.ready = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [5:0] pick_reg();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 6'($urandom_range(0, 30));
        if (p < 80) return 6'd31;
        if (p < 90) return 6'd32;
        return 6'($urandom_range(33, 63));
    endfunction

    // mostly legal immediates for the form, sometimes raw bits
    function automatic logic [63:0] pick_value(input logic [3:0] act, input logic wide);
        int p;
        longint sz;
        p = $urandom_range(0, 99);
        sz = wide ? 8 : 4;
        if (p < 15) return {$urandom, $urandom};
        if (p < 20) return -longint'($urandom_range(1, 64));
        case (act)
            ACT_ADDSUB_IMM: return $urandom_range(0, 4095);
            ACT_SHIFT: return $urandom_range(0, wide ? 63 : 31);
            ACT_MOVE_WIDE: return $urandom_range(0, 65535);
            ACT_MOV_IMM:
            begin
                logic [63:0] v;
                for (int i = 0; i < 4; i++)
                    case ($urandom_range(0, 3))
                        0: v[16*i +: 16] = 16'h0000;
                        1: v[16*i +: 16] = 16'hFFFF;
                        default: v[16*i +: 16] = 16'($urandom);
                    endcase
                return v;
            end
            ACT_LDST: return sz * $urandom_range(0, 4095) + (p < 25 ? 2 : 0);
            ACT_PAIR: return sz * ($urandom_range(0, 127) - 64);
            ACT_B: return 4 * ($urandom_range(0, 65535) - 32768);
            default: return 4 * ($urandom_range(0, 4095) - 2048) + (p < 25 ? 1 : 0);
        endcase
    endfunction

    task automatic send(input req_t q);
        req.data <= q;
        req.valid <= 1'b1;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic idle_src(input int n);
        if (n > 0)
        begin
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_mk(input logic [3:0] act, input logic [1:0] var_i, input logic wide,
                           input logic [5:0] d, input logic [5:0] n, input logic [5:0] m,
                           input logic [63:0] v);
        req_t q;
        q = '0;
        q.action = act; q.variant = var_i; q.wide_form = wide;
        q.reg_d = d; q.reg_n = n; q.reg_m = m; q.reg_a = 6'd7;
        q.cond = 4'd1; q.option_flag = 1'b1; q.chunk_shift = 6'd16; q.value = v;
        send(q);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold)
                res.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
                res.ready <= 1'b1;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        req_t q;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every form, field extremes and the named special cases
        send_mk(ACT_ADDSUB_REG, 2'd3, 1'b1, 6'd0, 6'd30, 6'd31, 64'd0);
        send_mk(ACT_ADDSUB_IMM, 2'd0, 1'b1, 6'd32, 6'd32, 6'd0, 64'd4095);
        send_mk(ACT_ADDSUB_IMM, 2'd2, 1'b0, 6'd32, 6'd1, 6'd0, 64'd1);   // sp in zero slot
        send_mk(ACT_ADDSUB_IMM, 2'd1, 1'b0, 6'd1, 6'd31, 6'd0, 64'd4096); // range first
        send_mk(ACT_MUL_ADD, 2'd1, 1'b1, 6'd1, 6'd2, 6'd63, 64'd0);      // reg above 32
        send_mk(ACT_SDIV, 2'd0, 1'b0, 6'd3, 6'd4, 6'd5, 64'd0);
        send_mk(ACT_LOGIC, 2'd3, 1'b1, 6'd31, 6'd31, 6'd31, 64'd0);
        send_mk(ACT_SHIFT, 2'd0, 1'b1, 6'd1, 6'd2, 6'd0, 64'd63);
        send_mk(ACT_SHIFT, 2'd3, 1'b0, 6'd1, 6'd2, 6'd0, 64'd0);         // unused variant
        send_mk(ACT_MOVE_WIDE, 2'd1, 1'b0, 6'd1, 6'd0, 6'd0, 64'hFFFF);
        send_mk(ACT_MOV_IMM, 2'd0, 1'b1, 6'd9, 6'd0, 6'd0, 64'h1234_5678_9ABC_DEF0);
        send_mk(ACT_MOV_IMM, 2'd0, 1'b1, 6'd9, 6'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_mk(ACT_MOV_IMM, 2'd0, 1'b1, 6'd9, 6'd0, 6'd0, 64'hFFFF_0000_FFFF_0000); // tie
        send_mk(ACT_MOV_IMM, 2'd0, 1'b0, 6'd9, 6'd0, 6'd0, 64'h8000_0000_0000_0000);
        send_mk(ACT_LDST, 2'd1, 1'b1, 6'd0, 6'd32, 6'd0, 64'd32760);
        send_mk(ACT_LDST, 2'd0, 1'b0, 6'd0, 6'd1, 6'd0, -64'sd4);         // negative offset
        send_mk(ACT_PAIR, 2'd1, 1'b1, 6'd3, 6'd3, 6'd4, 64'd8);          // base overlap
        send_mk(ACT_PAIR, 2'd1, 1'b0, 6'd5, 6'd32, 6'd5, -64'sd256);     // same ldp regs
        send_mk(ACT_B, 2'd1, 1'b0, 6'd0, 6'd0, 6'd0, -64'sd134217728);
        send_mk(ACT_BCOND, 2'd0, 1'b0, 6'd0, 6'd0, 6'd0, 64'd1048572);
        send_mk(ACT_CBZ, 2'd1, 1'b1, 6'd32, 6'd0, 6'd0, 64'd2);          // offset first
        send_mk(ACT_REGBRANCH, 2'd3, 1'b1, 6'd0, 6'd30, 6'd0, 64'd0);
        q = '0; q.action = ACT_CSET; q.cond = 4'd14; send(q);
        q.cond = 4'd15; q.reg_d = 6'd5; q.wide_form = 1'b1; send(q);
        send_mk(ACT_MOV, 2'd0, 1'b1, 6'd32, 6'd31, 6'd0, 64'd0);
        wait_drained();

        // long receiver hold-off while requests keep coming
        fork
            begin
                sink_hold = 1'b1;
                repeat (60) @(posedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_mk(ACT_MOV_IMM, 2'd0, 1'b1, 6'($urandom_range(0, 30)), 6'd0, 6'd0,
                        {$urandom, $urandom});
        join
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            q.action = 4'($urandom);
            q.variant = 2'($urandom);
            q.wide_form = 1'($urandom);
            q.reg_d = pick_reg();
            q.reg_n = pick_reg();
            q.reg_m = ($urandom_range(0, 9) == 0) ? q.reg_d : pick_reg();
            q.reg_a = pick_reg();
            q.cond = 4'($urandom);
            q.option_flag = 1'($urandom);
            q.chunk_shift = ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                        : 6'(16 * $urandom_range(0, 3));
            q.value = pick_value(q.action, q.wide_form);
            send(q);
            if (i == N_RANDOM / 2)
                wait_drained();
            else if ($urandom_range(0, 2) == 0)
                idle_src(gap_len());
        end
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
